@@ src/sphk_pkg.sv @@
package sphk_pkg;

    localparam int FRAC_BITS = 16;
    localparam int EXP_W     = 12;

    localparam int SQRT_STAGES = 16;   // two root bits per stage
    localparam int DIV_STAGES  = 16;   // two quotient bits per stage
    localparam int MUL_STEPS   = 12;   // longest chain: poly6 value, 3 + 9 products

    localparam logic [2:0] OP_POLY6       = 3'd0;
    localparam logic [2:0] OP_POLY6_GRAD  = 3'd1;
    localparam logic [2:0] OP_SPIKY2      = 3'd2;
    localparam logic [2:0] OP_SPIKY2_GRAD = 3'd3;
    localparam logic [2:0] OP_SPIKY3      = 3'd4;
    localparam logic [2:0] OP_SPIKY3_GRAD = 3'd5;

    // |r| below 1e-5, on the raw square
    localparam logic [63:0] TINY_R2 =
        ((64'd1 << (2 * FRAC_BITS)) - 64'd1) / 64'd10000000000;

    typedef logic signed [EXP_W-1:0] t_exp;
    typedef logic signed [EXP_W:0]   t_sexp;

    // pseudo-float: m * 2^e, m zero or in [2^31, 2^32)
    typedef struct packed {
        logic [31:0] m;
        t_exp        e;
    } t_pf;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] kernel_value;
        logic signed [31:0] grad_x;
        logic signed [31:0] grad_y;
        logic signed [31:0] grad_z;
        logic               saturated;
    } t_result;

    // radius-derived values from the configuration unit
    typedef struct packed {
        logic [30:0] hraw;
        logic [61:0] h2;
        t_pf         ih;
    } t_hcfg;

    function automatic logic [6:0] lzc64(input logic [63:0] x);
        logic [6:0] n;
        n = 7'd64;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) n = 7'(63 - i);
        end
        return n;
    endfunction

    function automatic logic [5:0] lzc32(input logic [31:0] x);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) n = 6'(31 - i);
        end
        return n;
    endfunction

    // truncating product of two normalised values
    function automatic t_pf pf_mul(input t_pf a, input t_pf b);
        logic [63:0] p;
        t_pf         r;
        p = 64'(a.m) * 64'(b.m);
        if (a.m == 32'd0 || b.m == 32'd0) begin
            r = '0;
        end else if (p[63]) begin
            r.m = p[63:32];
            r.e = a.e + b.e + t_exp'(32);
        end else begin
            r.m = p[62:31];
            r.e = a.e + b.e + t_exp'(31);
        end
        return r;
    endfunction

    // (num / 2^log2den) / pi, elaboration only
    function automatic t_pf pf_coef(input int unsigned num, input int log2den);
        logic [31:0] m;
        int          e;
        t_pf         a;
        t_pf         ip;
        m = 32'(num);
        e = -log2den;
        while (m < 32'h8000_0000) begin
            m = m << 1;
            e = e - 1;
        end
        a.m  = m;
        a.e  = t_exp'(e);
        ip.m = 32'hA2F9_836E;
        ip.e = t_exp'(-33);
        return pf_mul(a, ip);
    endfunction

    localparam t_pf COEF_POLY6      = pf_coef(315, 6);
    localparam t_pf COEF_POLY6_GRAD = pf_coef(945, 5);
    localparam t_pf COEF_SPIKY2     = pf_coef(15, 1);
    localparam t_pf COEF_15         = pf_coef(15, 0);
    localparam t_pf COEF_45         = pf_coef(45, 0);

    function automatic t_pf op_coef(input logic [2:0] op);
        t_pf c;
        case (op)
            OP_POLY6:       c = COEF_POLY6;
            OP_POLY6_GRAD:  c = COEF_POLY6_GRAD;
            OP_SPIKY2:      c = COEF_SPIKY2;
            OP_SPIKY2_GRAD: c = COEF_15;
            OP_SPIKY3:      c = COEF_15;
            OP_SPIKY3_GRAD: c = COEF_45;
            default:        c = '0;
        endcase
        return c;
    endfunction

    // products by d, then by 1/h
    function automatic logic [3:0] op_npow(input logic [2:0] op);
        logic [3:0] n;
        case (op)
            OP_POLY6:       n = 4'd3;
            OP_POLY6_GRAD:  n = 4'd2;
            OP_SPIKY2:      n = 4'd2;
            OP_SPIKY2_GRAD: n = 4'd1;
            OP_SPIKY3:      n = 4'd3;
            OP_SPIKY3_GRAD: n = 4'd2;
            default:        n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [3:0] op_nih(input logic [2:0] op);
        logic [3:0] n;
        case (op)
            OP_POLY6:       n = 4'd9;
            OP_POLY6_GRAD:  n = 4'd9;
            OP_SPIKY2:      n = 4'd5;
            OP_SPIKY2_GRAD: n = 4'd5;
            OP_SPIKY3:      n = 4'd6;
            OP_SPIKY3_GRAD: n = 4'd6;
            default:        n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

@@ src/sphk_sqrt.sv @@
module sphk_sqrt (
    input  logic        i_clk,
    input  logic [63:0] i_x,
    output logic [31:0] o_root
);

    logic [33:0] r_rem  [sphk_pkg::SQRT_STAGES];
    logic [31:0] r_root [sphk_pkg::SQRT_STAGES];
    logic [63:0] r_x    [sphk_pkg::SQRT_STAGES];

    for (genvar s = 0; s < sphk_pkg::SQRT_STAGES; s++) begin : g_stage
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] x_in;
        logic [33:0] n_rem;
        logic [31:0] n_root;
        logic [63:0] n_x;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = i_x;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
            assign x_in    = r_x[s-1];
        end

        always_comb begin
            logic [33:0] trial;
            n_rem  = rem_in;
            n_root = root_in;
            n_x    = x_in;
            for (int i = 0; i < 2; i++) begin
                n_rem = {n_rem[31:0], n_x[63:62]};
                trial = {n_root, 2'b01};
                if (n_rem >= trial) begin
                    n_rem  = n_rem - trial;
                    n_root = {n_root[30:0], 1'b1};
                end else begin
                    n_root = {n_root[30:0], 1'b0};
                end
                n_x = {n_x[61:0], 2'b00};
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= n_rem;
            r_root[s] <= n_root;
            r_x[s]    <= n_x;
        end
    end

    assign o_root = r_root[sphk_pkg::SQRT_STAGES-1];

endmodule

@@ src/sphk_cfg.sv @@
module sphk_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [30:0]          i_cfg_data,
    output logic                 o_cfg_ready,
    output logic                 o_busy,
    output sphk_pkg::t_hcfg      o_h
);

    localparam logic [5:0] LAST_STEP = 6'd32;   // 33 quotient bits

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_NORM = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    t_state              r_state;
    logic [30:0]         r_hraw;
    logic [61:0]         r_h2;
    logic [31:0]         r_hm;
    sphk_pkg::t_exp      r_he;
    logic [31:0]         r_rem;
    logic [32:0]         r_q;
    logic [5:0]          r_cnt;
    sphk_pkg::t_pf       r_ih;

    logic [5:0]          lz;
    logic [32:0]         rem2;

    assign lz   = sphk_pkg::lzc32({1'b0, r_hraw});
    assign rem2 = {r_rem, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_NORM;
            r_hraw  <= 31'd65536;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_cfg_valid) begin
                        r_hraw  <= i_cfg_data;
                        r_state <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == LAST_STEP) r_state <= ST_FIN;
                end
                ST_FIN: begin
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // 2^63 / m_h by restoring division, one bit a cycle
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_NORM: begin
                r_hm  <= 32'({1'b0, r_hraw} << lz);
                r_he  <= sphk_pkg::t_exp'(-sphk_pkg::FRAC_BITS) - sphk_pkg::t_exp'(lz);
                r_h2  <= 62'(r_hraw) * 62'(r_hraw);
                r_rem <= 32'h4000_0000;
                r_q   <= '0;
            end
            ST_DIV: begin
                if (rem2 >= {1'b0, r_hm}) begin
                    r_rem <= 32'(rem2 - {1'b0, r_hm});
                    r_q   <= {r_q[31:0], 1'b1};
                end else begin
                    r_rem <= rem2[31:0];
                    r_q   <= {r_q[31:0], 1'b0};
                end
            end
            ST_FIN: begin
                if (r_hm == 32'd0) begin
                    r_ih <= '0;
                end else if (r_q[32]) begin
                    r_ih.m <= r_q[32:1];
                    r_ih.e <= sphk_pkg::t_exp'(-62) - r_he;
                end else begin
                    r_ih.m <= r_q[31:0];
                    r_ih.e <= sphk_pkg::t_exp'(-63) - r_he;
                end
            end
            default: ;
        endcase
    end

    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_busy      = (r_state != ST_IDLE);
    assign o_h.hraw    = r_hraw;
    assign o_h.h2      = r_h2;
    assign o_h.ih      = r_ih;

endmodule

@@ src/sph_poly6_spiky_kernel_unit.sv @@
// SPH smoothing kernel evaluator: poly6, spiky squared and spiky cubed,
// value or gradient, for one offset vector against the radius h.
// Command channel: i_cmd is taken at a rising edge with start high and busy
// low. Each command gives one result on o_result, shown for exactly one
// cycle with o_result_valid high; the result is taken at the edge ending
// that cycle and cannot be held off.
// Throughput: one command per cycle while busy is low, set by the fully
// pipelined datapath (16-stage square root, 12 multiplier stages, 16-stage
// divider for the 1/|r| term).
// Radius: written through i_cfg_valid / o_cfg_ready / i_cfg_data while no
// command is in flight. A write starts a reciprocal of h, one quotient bit
// a cycle; busy stays high and o_cfg_ready low meanwhile.
// Reset loads h = 1.0 and runs the same sequence, empties the pipeline and
// drops the strobe.
module sph_poly6_spiky_kernel_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  sphk_pkg::t_cmd      i_cmd,
    output logic                o_result_valid,
    output sphk_pkg::t_result   o_result,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [30:0]         i_cfg_data
);

    typedef struct packed {
        logic                 vld;
        logic                 kill;
        logic [2:0]           op;
        logic [2:0]           pos;
        logic [4:0]           k;
        logic [61:0]          d2;
        sphk_pkg::t_pf [2:0]  a;    // raw |r_i| in m until normalised
        sphk_pkg::t_pf        rlen;
        sphk_pkg::t_pf        d;
        sphk_pkg::t_pf        s;
    } t_ctx;

    localparam sphk_pkg::t_sexp SH_OVF  = sphk_pkg::t_sexp'(32);
    localparam sphk_pkg::t_sexp SH_ZERO = sphk_pkg::t_sexp'(40);

    function automatic logic [63:0] toq_w(input sphk_pkg::t_pf x);
        sphk_pkg::t_sexp sh;
        sphk_pkg::t_sexp t;
        logic [63:0]     w;
        sh = sphk_pkg::t_sexp'(x.e) + sphk_pkg::t_sexp'(sphk_pkg::FRAC_BITS);
        t  = -sh;
        w  = '0;
        if (x.m != 32'd0) begin
            if (!sh[sphk_pkg::EXP_W]) begin
                if (sh >= SH_OVF) w = '1;
                else w = 64'(x.m) << sh[4:0];
            end else if (t < SH_ZERO) begin
                // round half away from zero on the magnitude
                w = (64'(x.m) + (64'd1 << (t[5:0] - 6'd1))) >> t[5:0];
            end
        end
        return w;
    endfunction

    // {clipped, value}
    function automatic logic [32:0] toq_fin(input logic [63:0] w, input logic neg);
        logic [63:0] lim;
        logic [31:0] v;
        logic        sat;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        sat = (w > lim);
        v   = sat ? lim[31:0] : w[31:0];
        return {sat, neg ? -v : v};
    endfunction

    sphk_pkg::t_hcfg h;
    logic            cfg_busy;

    sphk_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_busy      (cfg_busy),
        .o_h         (h)
    );

    assign busy = cfg_busy;

    // input register
    logic           r_p0_vld;
    sphk_pkg::t_cmd r_p0_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p0_vld <= 1'b0;
        else          r_p0_vld <= start && !busy;
        r_p0_cmd <= i_cmd;
    end

    // P1: magnitudes and squares
    t_ctx        n_c1, r_c1;
    logic [63:0] n_sq [3];
    logic [63:0] r_sq [3];

    always_comb begin
        logic signed [31:0] off [3];
        logic [31:0]        mag;
        off[0] = r_p0_cmd.offset_x;
        off[1] = r_p0_cmd.offset_y;
        off[2] = r_p0_cmd.offset_z;
        n_c1     = '0;
        n_c1.vld = r_p0_vld;
        n_c1.op  = r_p0_cmd.opcode;
        for (int i = 0; i < 3; i++) begin
            mag           = off[i][31] ? 32'(-off[i]) : 32'(off[i]);
            n_c1.pos[i]   = !off[i][31] && (off[i] != 32'sd0);
            n_c1.a[i].m   = mag;
            n_sq[i]       = 64'(mag) * 64'(mag);
        end
    end

    // P2: |r|^2 and normalised components
    t_ctx        n_c2, r_c2;
    logic [63:0] n_r2, r_r2;

    always_comb begin
        logic [5:0] lz;
        n_c2 = r_c1;
        n_r2 = r_sq[0] + r_sq[1] + r_sq[2];
        for (int i = 0; i < 3; i++) begin
            lz            = sphk_pkg::lzc32(r_c1.a[i].m);
            n_c2.a[i].m   = r_c1.a[i].m << lz;
            n_c2.a[i].e   = sphk_pkg::t_exp'(-sphk_pkg::FRAC_BITS) - sphk_pkg::t_exp'(lz);
        end
    end

    // P3: range tests, root pre-scale
    t_ctx        n_c3, r_c3;
    logic [63:0] r_p3_r2;

    always_comb begin
        logic [6:0] lz;
        logic       grad;
        lz      = sphk_pkg::lzc64(r_r2);
        grad    = r_c2.op[0];
        n_c3    = r_c2;
        n_c3.k  = (r_r2 == 64'd0) ? 5'd0 : lz[5:1];
        n_c3.d2 = h.h2 - r_r2[61:0];
        n_c3.kill = (r_c2.op > sphk_pkg::OP_SPIKY3_GRAD) || (h.hraw == 31'd0)
                  || (r_r2 > {2'b00, h.h2})
                  || (grad && r_c2.op >= sphk_pkg::OP_SPIKY2 && r_r2 <= sphk_pkg::TINY_R2);
    end

    // P4: scale |r|^2 by 4^k
    t_ctx        r_c4;
    logic [63:0] r_p4_x;
    logic [31:0] root;
    t_ctx        r_sq_ctx [sphk_pkg::SQRT_STAGES];

    sphk_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_x    (r_p4_x),
        .o_root (root)
    );

    // P5: choose d operand, take distance
    t_ctx            n_c5, r_c5;
    logic [63:0]     n_dval, r_dval;
    logic [6:0]      r_dlz;
    sphk_pkg::t_exp  n_de0, r_de0;

    always_comb begin
        t_ctx           c;
        logic           spiky;
        sphk_pkg::t_exp ek;
        c     = r_sq_ctx[sphk_pkg::SQRT_STAGES-1];
        spiky = (c.op >= sphk_pkg::OP_SPIKY2);
        ek    = sphk_pkg::t_exp'(-sphk_pkg::FRAC_BITS) - sphk_pkg::t_exp'(c.k);
        n_c5  = c;
        n_c5.rlen.m = root;
        n_c5.rlen.e = ek;
        if (spiky) begin
            n_dval = ({33'd0, h.hraw} << c.k) - {32'd0, root};
            n_de0  = ek;
        end else begin
            n_dval = {2'b00, c.d2};
            n_de0  = sphk_pkg::t_exp'(-2 * sphk_pkg::FRAC_BITS);
        end
    end

    // P6: normalise d, load coefficient
    t_ctx n_c6, r_c6;

    always_comb begin
        logic [63:0] sh;
        sh          = r_dval << r_dlz;
        n_c6        = r_c5;
        n_c6.d.m    = sh[63:32];
        n_c6.d.e    = r_de0 + sphk_pkg::t_exp'(32) - sphk_pkg::t_exp'(r_dlz);
        n_c6.s      = sphk_pkg::op_coef(r_c5.op);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
            for (int i = 0; i < sphk_pkg::SQRT_STAGES; i++) r_sq_ctx[i] <= '0;
        end else begin
            r_c1 <= n_c1;
            r_c2 <= n_c2;
            r_c3 <= n_c3;
            r_c4 <= r_c3;
            r_c5 <= n_c5;
            r_c6 <= n_c6;
            r_sq_ctx[0] <= r_c4;
            for (int i = 1; i < sphk_pkg::SQRT_STAGES; i++) r_sq_ctx[i] <= r_sq_ctx[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq    <= n_sq;
        r_r2    <= n_r2;
        r_p3_r2 <= r_r2;
        r_p4_x  <= r_p3_r2 << {r_c3.k, 1'b0};
        r_dval  <= n_dval;
        r_dlz   <= sphk_pkg::lzc64(n_dval);
        r_de0   <= n_de0;
    end

    // product chain: coef * d^npow * ih^nih, left to right
    t_ctx r_m_ctx [sphk_pkg::MUL_STEPS];

    for (genvar j = 0; j < sphk_pkg::MUL_STEPS; j++) begin : g_mul
        t_ctx c_in;
        t_ctx n_c;

        if (j == 0) begin : g_first
            assign c_in = r_c6;
        end else begin : g_next
            assign c_in = r_m_ctx[j-1];
        end

        always_comb begin
            logic [3:0] np;
            logic [3:0] ni;
            np  = sphk_pkg::op_npow(c_in.op);
            ni  = sphk_pkg::op_nih(c_in.op);
            n_c = c_in;
            if (4'(j) < np)           n_c.s = sphk_pkg::pf_mul(c_in.s, c_in.d);
            else if (4'(j) < np + ni) n_c.s = sphk_pkg::pf_mul(c_in.s, h.ih);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_m_ctx[j] <= '0;
            else          r_m_ctx[j] <= n_c;
        end
    end

    // s / |r|: (m_s * 2^31) / m_rlen, restoring, two bits a stage
    t_ctx        r_d_ctx [sphk_pkg::DIV_STAGES];
    logic [32:0] r_drem  [sphk_pkg::DIV_STAGES];
    logic [31:0] r_dq    [sphk_pkg::DIV_STAGES];

    for (genvar st = 0; st < sphk_pkg::DIV_STAGES; st++) begin : g_div
        t_ctx        c_in;
        logic [32:0] rem_in;
        logic [31:0] q_in;
        logic [32:0] n_rem;
        logic [31:0] n_q;

        if (st == 0) begin : g_first
            assign c_in   = r_m_ctx[sphk_pkg::MUL_STEPS-1];
            assign rem_in = {1'b0, c_in.s.m};
            assign q_in   = '0;
        end else begin : g_next
            assign c_in   = r_d_ctx[st-1];
            assign rem_in = r_drem[st-1];
            assign q_in   = r_dq[st-1];
        end

        always_comb begin
            n_rem = rem_in;
            n_q   = q_in;
            for (int i = 0; i < 2; i++) begin
                if (n_rem >= {1'b0, c_in.rlen.m}) begin
                    n_rem = n_rem - {1'b0, c_in.rlen.m};
                    n_q   = {n_q[30:0], 1'b1};
                end else begin
                    n_q   = {n_q[30:0], 1'b0};
                end
                n_rem = {n_rem[31:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_d_ctx[st] <= '0;
            else          r_d_ctx[st] <= c_in;
            r_drem[st] <= n_rem;
            r_dq[st]   <= n_q;
        end
    end

    // Q: normalise quotient, pick final scale
    t_ctx n_cq, r_cq;

    always_comb begin
        t_ctx          c;
        logic [31:0]   qv;
        sphk_pkg::t_pf quo;
        c  = r_d_ctx[sphk_pkg::DIV_STAGES-1];
        qv = r_dq[sphk_pkg::DIV_STAGES-1];
        if (c.s.m == 32'd0 || c.rlen.m == 32'd0) begin
            quo = '0;
        end else if (qv[31]) begin
            quo.m = qv;
            quo.e = c.s.e - c.rlen.e - sphk_pkg::t_exp'(31);
        end else begin
            quo.m = {qv[30:0], 1'b0};
            quo.e = c.s.e - c.rlen.e - sphk_pkg::t_exp'(32);
        end
        n_cq = c;
        if (c.op == sphk_pkg::OP_SPIKY2_GRAD || c.op == sphk_pkg::OP_SPIKY3_GRAD) n_cq.s = quo;
    end

    // C: gradient components
    t_ctx          r_cc;
    sphk_pkg::t_pf n_prod [3];
    sphk_pkg::t_pf r_prod [3];

    always_comb begin
        for (int i = 0; i < 3; i++) n_prod[i] = sphk_pkg::pf_mul(r_cq.s, r_cq.a[i]);
    end

    // T1: magnitude to fixed point
    t_ctx        r_ct;
    logic [63:0] n_w [4];
    logic [63:0] r_w [4];

    always_comb begin
        n_w[0] = toq_w(r_cc.s);
        for (int i = 0; i < 3; i++) n_w[1+i] = toq_w(r_prod[i]);
    end

    // T2: clip, sign, mask
    sphk_pkg::t_result n_res, r_res;
    logic              r_out_vld;

    always_comb begin
        logic [32:0] kv;
        logic [32:0] gv [3];
        logic        grad;
        logic        live;
        grad  = r_ct.op[0];
        live  = !r_ct.kill;
        kv    = toq_fin(r_w[0], 1'b0);
        for (int i = 0; i < 3; i++) gv[i] = toq_fin(r_w[1+i], r_ct.pos[i]);
        n_res = '0;
        if (live && !grad) begin
            n_res.kernel_value = kv[31:0];
            n_res.saturated    = kv[32];
        end
        if (live && grad) begin
            n_res.grad_x    = gv[0][31:0];
            n_res.grad_y    = gv[1][31:0];
            n_res.grad_z    = gv[2][31:0];
            n_res.saturated = gv[0][32] | gv[1][32] | gv[2][32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cq      <= '0;
            r_cc      <= '0;
            r_ct      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_cq      <= n_cq;
            r_cc      <= r_cq;
            r_ct      <= r_cc;
            r_out_vld <= r_ct.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_w    <= n_w;
        r_res  <= n_res;
    end

    assign o_result_valid = r_out_vld;
    assign o_result       = r_res;

endmodule

@@ dv/sph_poly6_spiky_kernel_unit_tb.sv @@
`timescale 1ns / 1ps

module sph_poly6_spiky_kernel_unit_tb;

    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam int QUIET_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum logic [1:0] {K_CMD, K_CFG, K_DRAIN, K_IDLE} t_kind;

    typedef struct {
        t_kind          kind;
        sphk_pkg::t_cmd cmd;
        logic [30:0]    radius;
        int             idle_pct;
    } t_job;

    // pseudo-float used by the kernel predictor: m * 2^e
    typedef struct {
        longint unsigned m;
        int              e;
    } t_fp;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    sphk_pkg::t_cmd    i_cmd;
    logic              o_result_valid;
    sphk_pkg::t_result o_result;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [30:0]       i_cfg_data;

    t_job              jobs[$];
    sphk_pkg::t_result kernel_q[$];
    logic [30:0]       radius_now;
    int                idle_pct;
    int                quiet_cnt;
    int                cycle_cnt;
    int                err_cnt;

    sph_poly6_spiky_kernel_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic t_fp fp_norm(longint unsigned x, int e);
        t_fp r;
        r.m = 0;
        r.e = 0;
        if (x == 0) return r;
        while (x >= 64'h1_0000_0000) begin
            x = x >> 1;
            e++;
        end
        while (x < 64'h8000_0000) begin
            x = x << 1;
            e--;
        end
        r.m = x;
        r.e = e;
        return r;
    endfunction

    function automatic t_fp fp_mul(t_fp a, t_fp b);
        if (a.m == 0 || b.m == 0) return fp_norm(0, 0);
        return fp_norm(a.m * b.m, a.e + b.e);
    endfunction

    function automatic t_fp fp_recip(t_fp a);
        if (a.m == 0) return fp_norm(0, 0);
        return fp_norm(64'h8000_0000_0000_0000 / a.m, -63 - a.e);
    endfunction

    function automatic t_fp fp_div(t_fp a, t_fp b);
        if (a.m == 0 || b.m == 0) return fp_norm(0, 0);
        return fp_norm((a.m << 31) / b.m, a.e - b.e - 31);
    endfunction

    function automatic t_fp fp_coef(longint unsigned num, int log2den);
        t_fp inv_pi;
        inv_pi.m = 64'hA2F9_836E;
        inv_pi.e = -33;
        return fp_mul(fp_norm(num, -log2den), inv_pi);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // round half away from zero, then clip to 32 bits signed
    function automatic logic [31:0] fp_to_fixed(t_fp a, bit neg, inout bit sat);
        longint unsigned lim;
        longint unsigned v;
        int              s;
        int              t;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        s   = a.e + sphk_pkg::FRAC_BITS;
        if (a.m == 0) return 32'd0;
        if (s >= 0) begin
            if (s >= 32) v = lim + 1;
            else v = a.m << s;
        end else begin
            t = -s;
            if (t >= 40) v = 0;
            else v = (a.m + (64'd1 << (t - 1))) >> t;
        end
        if (v > lim) begin
            v   = lim;
            sat = 1'b1;
        end
        return neg ? 32'(-v) : 32'(v);
    endfunction

    function automatic sphk_pkg::t_result kernel_predict(sphk_pkg::t_cmd c, logic [30:0] h);
        sphk_pkg::t_result res;
        longint signed     comp[3];
        longint unsigned   mag[3];
        longint unsigned   r2;
        longint unsigned   h2;
        longint unsigned   x;
        longint unsigned   root;
        bit                grad;
        bit                sat;
        t_fp               s;
        t_fp               ih;
        t_fp               d;
        t_fp               rlen;
        int                npow;
        int                nih;
        int                k;
        res     = '0;
        sat     = 1'b0;
        comp[0] = c.offset_x;
        comp[1] = c.offset_y;
        comp[2] = c.offset_z;
        for (int i = 0; i < 3; i++) mag[i] = comp[i] < 0 ? -comp[i] : comp[i];
        if (c.opcode > sphk_pkg::OP_SPIKY3_GRAD || h == 0) return res;
        r2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        h2 = longint'(h) * longint'(h);
        if (r2 > h2) return res;
        grad = c.opcode[0];
        // tiny distance guard for the spiky gradients
        if (grad && c.opcode >= sphk_pkg::OP_SPIKY2 &&
            r2 <= ((64'd1 << (2 * sphk_pkg::FRAC_BITS)) - 1) / 64'd10000000000) return res;
        ih = fp_recip(fp_norm(h, -sphk_pkg::FRAC_BITS));
        if (c.opcode < sphk_pkg::OP_SPIKY2) begin
            d    = fp_norm(h2 - r2, -2 * sphk_pkg::FRAC_BITS);
            s    = grad ? fp_coef(945, 5) : fp_coef(315, 6);
            npow = grad ? 2 : 3;
            nih  = 9;
        end else begin
            x = r2;
            k = 0;
            if (x != 0) begin
                while (x < (64'd1 << 62)) begin
                    x = x << 2;
                    k++;
                end
            end
            root = int_sqrt(x);
            d    = fp_norm((longint'(h) << k) - root, -(sphk_pkg::FRAC_BITS + k));
            rlen = fp_norm(root, -(sphk_pkg::FRAC_BITS + k));
            case (c.opcode)
                sphk_pkg::OP_SPIKY2: begin
                    s = fp_coef(15, 1); npow = 2; nih = 5;
                end
                sphk_pkg::OP_SPIKY2_GRAD: begin
                    s = fp_coef(15, 0); npow = 1; nih = 5;
                end
                sphk_pkg::OP_SPIKY3: begin
                    s = fp_coef(15, 0); npow = 3; nih = 6;
                end
                default: begin
                    s = fp_coef(45, 0); npow = 2; nih = 6;
                end
            endcase
        end
        for (int i = 0; i < npow; i++) s = fp_mul(s, d);
        for (int i = 0; i < nih; i++) s = fp_mul(s, ih);
        if (grad && c.opcode >= sphk_pkg::OP_SPIKY2) s = fp_div(s, rlen);
        if (!grad) begin
            res.kernel_value = fp_to_fixed(s, 1'b0, sat);
        end else begin
            if (mag[0] != 0)
                res.grad_x = fp_to_fixed(fp_mul(s, fp_norm(mag[0], -sphk_pkg::FRAC_BITS)),
                                         comp[0] > 0, sat);
            if (mag[1] != 0)
                res.grad_y = fp_to_fixed(fp_mul(s, fp_norm(mag[1], -sphk_pkg::FRAC_BITS)),
                                         comp[1] > 0, sat);
            if (mag[2] != 0)
                res.grad_z = fp_to_fixed(fp_mul(s, fp_norm(mag[2], -sphk_pkg::FRAC_BITS)),
                                         comp[2] > 0, sat);
        end
        res.saturated = sat;
        return res;
    endfunction

    // driver: one assignment per signal per edge
    always @(posedge i_clk) begin
        t_job head;
        bit   held_cmd;
        bit   held_cfg;
        logic n_start;
        logic n_cfg_valid;
        int   n_quiet;
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_cfg_valid <= 1'b0;
            quiet_cnt   <= 0;
        end else begin
            held_cmd    = 1'b0;
            held_cfg    = 1'b0;
            n_start     = 1'b0;
            n_cfg_valid = 1'b0;
            n_quiet     = quiet_cnt + 1;
            if (start && !busy) begin
                kernel_q.push_back(kernel_predict(i_cmd, radius_now));
                void'(jobs.pop_front());
                n_quiet = 0;
            end else if (start) begin
                held_cmd = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                radius_now = i_cfg_data;
                void'(jobs.pop_front());
            end else if (i_cfg_valid) begin
                held_cfg = 1'b1;
            end
            if (held_cmd) begin
                n_start = 1'b1;
            end else if (held_cfg) begin
                n_cfg_valid = 1'b1;
            end else if (jobs.size() != 0) begin
                head = jobs[0];
                case (head.kind)
                    K_CMD: begin
                        if ($urandom_range(99) >= idle_pct) begin
                            n_start = 1'b1;
                            i_cmd   <= head.cmd;
                        end
                    end
                    K_CFG: begin
                        // block must be empty before the radius changes
                        if (kernel_q.size() == 0 && quiet_cnt >= QUIET_CYCLES) begin
                            n_cfg_valid = 1'b1;
                            i_cfg_data  <= head.radius;
                        end
                    end
                    K_DRAIN: begin
                        if (kernel_q.size() == 0) void'(jobs.pop_front());
                    end
                    default: begin
                        idle_pct = head.idle_pct;
                        void'(jobs.pop_front());
                    end
                endcase
            end
            start       <= n_start;
            i_cfg_valid <= n_cfg_valid;
            quiet_cnt   <= n_quiet;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        sphk_pkg::t_result want;
        if (i_rst_n && o_result_valid) begin
            if (kernel_q.size() == 0) begin
                $error("result with nothing pending: %h", o_result);
                err_cnt++;
            end else begin
                want = kernel_q.pop_front();
                if (o_result.kernel_value !== want.kernel_value) begin
                    $error("kernel_value: expected %h, got %h",
                           want.kernel_value, o_result.kernel_value);
                    err_cnt++;
                end
                if (o_result.grad_x !== want.grad_x) begin
                    $error("grad_x: expected %h, got %h", want.grad_x, o_result.grad_x);
                    err_cnt++;
                end
                if (o_result.grad_y !== want.grad_y) begin
                    $error("grad_y: expected %h, got %h", want.grad_y, o_result.grad_y);
                    err_cnt++;
                end
                if (o_result.grad_z !== want.grad_z) begin
                    $error("grad_z: expected %h, got %h", want.grad_z, o_result.grad_z);
                    err_cnt++;
                end
                if (o_result.saturated !== want.saturated) begin
                    $error("saturated: expected %b, got %b",
                           want.saturated, o_result.saturated);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL sph_poly6_spiky_kernel_unit");
            $finish;
        end
    end

    logic [30:0] plan_radius;

    task automatic add_cmd(logic [2:0] op, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_job j;
        j.kind     = K_CMD;
        j.cmd      = '{opcode: op, offset_x: x, offset_y: y, offset_z: z};
        j.radius   = '0;
        j.idle_pct = 0;
        jobs.push_back(j);
    endtask

    task automatic add_ctl(t_kind kind, logic [30:0] radius, int pct);
        t_job j;
        j.kind     = kind;
        j.cmd      = '0;
        j.radius   = radius;
        j.idle_pct = pct;
        jobs.push_back(j);
        if (kind == K_CFG) plan_radius = radius;
    endtask

    function automatic logic [31:0] rand_comp(logic [30:0] lim);
        logic [31:0] v;
        v = $urandom_range(0, lim);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    task automatic add_random(int n);
        logic [2:0]  op;
        logic [31:0] c[3];
        logic [30:0] h;
        for (int i = 0; i < n; i++) begin
            h  = plan_radius;
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
            case ($urandom_range(0, 9))
                6: for (int a = 0; a < 3; a++) c[a] = $urandom;
                7: begin
                    c = '{0, 0, 0};
                    c[$urandom_range(0, 2)] = rand_comp(h);
                end
                8: begin
                    // just inside or outside the support
                    c = '{0, 0, 0};
                    c[$urandom_range(0, 2)] = h + $urandom_range(0, 4) - 2;
                end
                9: for (int a = 0; a < 3; a++) c[a] = 32'($signed($urandom_range(0, 2)) - 1);
                default: for (int a = 0; a < 3; a++) c[a] = rand_comp(h >> 1);
            endcase
            add_cmd(op, c[0], c[1], c[2]);
        end
    endtask

    initial begin
        int pcts[4];
        logic [30:0] radii[9];
        pcts        = '{0, 84, 38, 0};
        radii       = '{31'h3_0000, 31'd1, 31'd0, 31'h7FFF_FFFF, 31'($urandom),
                        31'h8000, 31'h40, 31'($urandom_range(1, 31'h10_0000)), 31'h1_0000};
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        radius_now  = 31'h1_0000;
        plan_radius = 31'h1_0000;
        idle_pct    = 0;
        quiet_cnt   = 0;
        cycle_cnt   = 0;
        err_cnt     = 0;

        // directed part at h = 1.0
        add_cmd(sphk_pkg::OP_POLY6,       32'h4000, 32'h2000, -32'sh1000);
        add_cmd(sphk_pkg::OP_POLY6_GRAD,  32'h4000, 32'h2000, -32'sh1000);
        add_cmd(sphk_pkg::OP_SPIKY2,      32'h4000, 32'h2000, -32'sh1000);
        add_cmd(sphk_pkg::OP_SPIKY2_GRAD, 32'h4000, 32'h2000, -32'sh1000);
        add_cmd(sphk_pkg::OP_SPIKY3,      32'h4000, 32'h2000, -32'sh1000);
        add_cmd(sphk_pkg::OP_SPIKY3_GRAD, 32'h4000, 32'h2000, -32'sh1000);
        // zero offset: spiky gradients hit the tiny-distance guard
        for (int op = 0; op < 6; op++) add_cmd(3'(op), 0, 0, 0);
        add_cmd(sphk_pkg::OP_POLY6,       32'h1_0000, 0, 0);
        add_cmd(sphk_pkg::OP_SPIKY3_GRAD, 0, -32'sh1_0000, 0);
        add_cmd(sphk_pkg::OP_POLY6_GRAD,  32'h1_0001, 0, 0);
        add_cmd(sphk_pkg::OP_POLY6,       32'h7FFF_FFFF, 32'h8000_0000, 0);
        add_cmd(OP_SPARE_6,               32'h1000, 0, 0);
        add_cmd(OP_SPARE_7,               0, 0, 32'h1000);
        add_cmd(sphk_pkg::OP_SPIKY2_GRAD, 1, 0, 0);
        add_cmd(sphk_pkg::OP_SPIKY3_GRAD, -32'sd1, -32'sd1, 1);
        add_cmd(sphk_pkg::OP_SPIKY3,      -32'sh8000, 32'h8000, -32'sh8000);

        for (int seg = 0; seg < 9; seg++) begin
            add_ctl(K_CFG, radii[seg], 0);
            add_ctl(K_IDLE, '0, pcts[seg % 4]);
            add_random(25);
            if (seg == 4) add_ctl(K_DRAIN, '0, 0);
            add_random(25);
        end

        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (jobs.size() != 0 || kernel_q.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("PASS sph_poly6_spiky_kernel_unit");
        end else begin
            $display("FAIL sph_poly6_spiky_kernel_unit");
        end
        $finish;
    end

endmodule
